/* src/snq_pkg.sv */
package snq_pkg;

    localparam int NoteW = 7;
    localparam int KeyW  = 5;
    localparam int ConfW = 16;
    localparam int CntW  = 32;
    localparam int PcN   = 12;

    localparam logic [NoteW-1:0] MaxNote = 7'd127;
    localparam logic [KeyW-1:0]  MaxKey  = 5'd23;
    localparam logic [KeyW-1:0]  NoKey   = 5'd24;
    localparam logic [ConfW-1:0] ConfRst = 16'd32768;

    localparam logic [3:0] MajorSteps [0:6] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};
    localparam logic [3:0] MinorSteps [0:6] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10};

    // operation codes carried in tuser
    localparam logic [1:0] FuncSnap    = 2'd0;
    localparam logic [1:0] FuncDetect  = 2'd1;
    localparam logic [1:0] FuncConsume = 2'd2;
    localparam logic [1:0] FuncClear   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CfgBypass    = 2'd0;
    localparam logic [1:0] CfgMinConf   = 2'd1;
    localparam logic [1:0] CfgManualEn  = 2'd2;
    localparam logic [1:0] CfgManualKey = 2'd3;

    typedef struct packed {
        logic [NoteW-1:0] note;
        logic             moved;
    } t_snap_res;

    function automatic logic [PcN-1:0] snq_make_mask(input logic [3:0] root,
                                                     input logic       minor);
        logic [PcN-1:0] m;
        logic [4:0]     s;
        m = '0;
        for (int i = 0; i < 7; i++) begin
            s = {1'b0, root} + {1'b0, (minor ? MinorSteps[i] : MajorSteps[i])};
            if (s >= 5'd24) begin
                s = s - 5'd24;
            end else if (s >= 5'd12) begin
                s = s - 5'd12;
            end
            m[s[3:0]] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [KeyW-1:0] snq_sat_key(input logic [KeyW-1:0] k);
        return (k > MaxKey) ? MaxKey : k;
    endfunction

endpackage

/* src/scale_note_quantizer.sv */
// pipeline: an input register, then one pass of scale logic into the result
// register; throughput: one beat per cycle while m_axis_tready is not held low;
// the result register holds a finished beat while the next is taken
// reset: synchronous, active low; clears the scale, key, counters, event and
// configuration to their defaults; a configuration write is taken once the
// input register is empty
module scale_note_quantizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // note_in[6:0], key_root[10:7], key_minor[11], key_conf[27:12],
    // key_number[32:28], zero pad
    input  logic [39:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // note_out[6:0], event_valid[7], snap_from[14:8], snap_to[21:15],
    // total_notes[53:22], snapped_notes[85:54], active_key_out[90:86], zero pad
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import snq_pkg::*;

    // configuration
    logic             r_bypass;
    logic [ConfW-1:0] r_min_conf;
    logic             r_manual_en;
    logic [KeyW-1:0]  r_manual_key;

    // architectural state
    logic [PcN-1:0]   r_mask,     n_mask;
    logic             r_scale_ok, n_scale_ok;
    logic [KeyW-1:0]  r_key,      n_key;
    logic [CntW-1:0]  r_total,    n_total;
    logic [CntW-1:0]  r_snapped,  n_snapped;
    logic [NoteW-1:0] r_from,     n_from;
    logic [NoteW-1:0] r_to,       n_to;
    logic             r_pending,  n_pending;
    logic             n_event;
    logic [NoteW-1:0] n_note_out;

    // input stage
    logic             r_in_valid;
    logic [1:0]       r_func;
    logic [NoteW-1:0] r_note;
    logic [3:0]       r_root;
    logic             r_minor;
    logic [ConfW-1:0] r_conf;
    logic [KeyW-1:0]  r_knum;

    // result stage
    logic             r_out_valid;
    logic [95:0]      r_out_data;

    logic             advance;
    logic             work_en;
    t_snap_res        snap;
    logic [KeyW-1:0]  cfg_key;
    logic [KeyW-1:0]  man_key;

    assign advance       = !r_out_valid || m_axis_tready;
    assign work_en       = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    // no write while a beat waits in the input register
    assign o_cfg_ready   = !r_in_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    snq_snap u_snap (
        .i_mask (r_mask),
        .i_note (r_note),
        .o_res  (snap)
    );

    always_comb begin
        n_mask     = r_mask;
        n_scale_ok = r_scale_ok;
        n_key      = r_key;
        n_total    = r_total;
        n_snapped  = r_snapped;
        n_from     = r_from;
        n_to       = r_to;
        n_pending  = r_pending;
        n_event    = 1'b0;
        n_note_out = r_note;
        case (r_func)
            FuncSnap: begin
                n_total = r_total + 1'b1;
                if (!r_bypass && r_scale_ok) begin
                    n_note_out = snap.note;
                    if (snap.moved) begin
                        n_snapped = r_snapped + 1'b1;
                        n_from    = r_note;
                        n_to      = snap.note;
                        n_pending = 1'b1;
                    end
                end
            end
            FuncDetect: begin
                if (!r_manual_en && (r_conf >= r_min_conf)) begin
                    n_mask     = snq_make_mask(r_root, r_minor);
                    n_scale_ok = 1'b1;
                    n_key      = snq_sat_key(r_knum);
                end
            end
            FuncConsume: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    n_event   = 1'b1;
                end
            end
            default: begin
                n_total   = '0;
                n_snapped = '0;
                n_from    = '0;
                n_to      = '0;
                n_pending = 1'b0;
            end
        endcase
    end

    // manual key to apply: the new one on a key write, the stored one otherwise
    assign cfg_key = snq_sat_key(i_cfg_data[KeyW-1:0]);
    assign man_key = (i_cfg_index == CfgManualKey) ? cfg_key : r_manual_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass     <= 1'b0;
            r_min_conf   <= ConfRst;
            r_manual_en  <= 1'b0;
            r_manual_key <= '0;
            r_mask       <= '0;
            r_scale_ok   <= 1'b0;
            r_key        <= NoKey;
            r_total      <= '0;
            r_snapped    <= '0;
            r_from       <= '0;
            r_to         <= '0;
            r_pending    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CfgBypass:    r_bypass     <= i_cfg_data[0];
                CfgMinConf:   r_min_conf   <= i_cfg_data;
                CfgManualEn:  r_manual_en  <= i_cfg_data[0];
                CfgManualKey: r_manual_key <= cfg_key;
                default:      ;
            endcase
            if (((i_cfg_index == CfgManualEn) && i_cfg_data[0]) ||
                ((i_cfg_index == CfgManualKey) && r_manual_en)) begin
                r_mask     <= snq_make_mask((man_key >= 5'd12) ? 4'(man_key - 5'd12)
                                                               : man_key[3:0],
                                            man_key >= 5'd12);
                r_scale_ok <= 1'b1;
                r_key      <= man_key;
            end
        end else if (work_en) begin
            r_mask     <= n_mask;
            r_scale_ok <= n_scale_ok;
            r_key      <= n_key;
            r_total    <= n_total;
            r_snapped  <= n_snapped;
            r_from     <= n_from;
            r_to       <= n_to;
            r_pending  <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func  <= s_axis_tuser;
            r_note  <= s_axis_tdata[6:0];
            r_root  <= s_axis_tdata[10:7];
            r_minor <= s_axis_tdata[11];
            r_conf  <= s_axis_tdata[27:12];
            r_knum  <= s_axis_tdata[32:28];
        end
        if (work_en) begin
            r_out_data <= {5'd0, n_key, n_snapped, n_total, n_to, n_from,
                           n_event, n_note_out};
        end
    end

endmodule

/* src/snq_snap.sv */
module snq_snap (
    input  logic [snq_pkg::PcN-1:0]   i_mask,
    input  logic [snq_pkg::NoteW-1:0] i_note,
    output snq_pkg::t_snap_res        o_res
);
    import snq_pkg::*;

    logic [14:0]          prod;
    logic [3:0]           quot;
    logic [7:0]           quot12;
    logic [3:0]           pc;
    logic [2*PcN-1:0]     dbl;
    logic [PcN-1:0]       rot;
    logic                 found;
    logic                 go_up;
    logic [2:0]           reach;
    logic [NoteW:0]       up_sum;
    logic [NoteW-1:0]     res;

    // note / 12 by reciprocal: exact for 7-bit notes
    assign prod   = {8'd0, i_note} * 15'd171;
    assign quot   = prod[14:11];
    assign quot12 = {4'd0, quot} * 8'd12;
    assign pc     = 4'(({1'b0, i_note} - quot12));

    // rotate so that bit 0 is the pitch class of the note
    assign dbl = {i_mask, i_mask} >> pc;
    assign rot = dbl[PcN-1:0];

    always_comb begin
        found = 1'b0;
        go_up = 1'b0;
        reach = 3'd0;
        // nearest distance wins, upward wins a tie
        for (int d = 6; d >= 1; d--) begin
            if (rot[PcN-d]) begin
                found = 1'b1;
                go_up = 1'b0;
                reach = 3'(d);
            end
            if (rot[d]) begin
                found = 1'b1;
                go_up = 1'b1;
                reach = 3'(d);
            end
        end
    end

    assign up_sum = {1'b0, i_note} + {5'd0, reach};

    always_comb begin
        res = i_note;
        if (!rot[0] && found) begin
            if (go_up) begin
                res = (up_sum > {1'b0, MaxNote}) ? MaxNote : up_sum[NoteW-1:0];
            end else begin
                res = (i_note >= {4'd0, reach}) ? (i_note - {4'd0, reach}) : '0;
            end
        end
    end

    assign o_res.note  = res;
    assign o_res.moved = (res != i_note);

endmodule
